// ===== sv/ffpra_pkg.sv =====
// ----------------------------------------------------------------------------
// First-fit page range allocator: shared package
// Request and result types, region table entry, status codes and the states
// of the request sequencer.
// ----------------------------------------------------------------------------
package ffpra_pkg;

    localparam int PAGE_W    = 36;
    localparam int CNT_W     = 20;
    // Wide enough for base + offset + count without wrapping.
    localparam int SUM_W     = PAGE_W + 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_PAGE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_PAGE  = 2'd1;

    typedef enum logic [0:0] {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } req_kind_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_MISMATCH  = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_FULL      = 3'd3,
        ST_EXHAUSTED = 3'd4
    } status_t;

    typedef struct packed {
        req_kind_t          req_type;
        logic [CNT_W-1:0]   page_count;
        logic [PAGE_W-1:0]  start_page;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic [PAGE_W-1:0]  region_page;
        logic [CNT_W-1:0]   region_count;
    } rsp_t;

    typedef struct packed {
        logic [PAGE_W-1:0]  start_page;
        logic [CNT_W-1:0]   page_count;
        logic               free_mark;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_APP_REM,
        S_APP_USED,
        S_RESP
    } state_t;

    typedef struct packed {
        logic idle;
        logic res_valid;
    } seq_stat_t;

endpackage

// ===== sv/first_fit_page_range_allocator_core.sv =====
// ----------------------------------------------------------------------------
// First-fit page range allocator core
// Keeps an ordered table of page regions and serves allocate and free
// requests against it, first fit with split, bump allocation as fallback.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Content
//  req       in         req_valid/req_stall  req_type, page_count, start_page
//  rsp       out        rsp_valid/rsp_stall  status, region_page, region_count
//  cfg       in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One request is handled at a time. The scan reads the table memory one
// entry per cycle, over the used regions in the table. A split also moves
// each entry behind the removed one down one place through the same single
// read and write port, and then appends the remainder and the used region.
// Reset clears the region count and the bump offset; the table memory itself
// is not cleared, as only entries below the region count are ever read.
// A stalled result sits in the output register while the next request is
// taken; the sequencer only waits if that register is still occupied.
//
module first_fit_page_range_allocator_core #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_stall,
    input  ffpra_pkg::req_t                  req,
    output logic                             rsp_valid,
    input  logic                             rsp_stall,
    output ffpra_pkg::rsp_t                  rsp,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ffpra_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ffpra_pkg::PAGE_W-1:0]     cfg_data
);

    // Table address width and the width of the region count, which must be
    // able to hold the depth itself.
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int UW    = $clog2(TABLE_DEPTH + 1);

    logic [ffpra_pkg::PAGE_W-1:0] base_reg, base_next;
    logic [ffpra_pkg::PAGE_W-1:0] end_reg, end_next;
    logic                         rsp_valid_reg, rsp_valid_next;
    ffpra_pkg::rsp_t              rsp_reg, rsp_next;

    ffpra_pkg::seq_stat_t stat;
    ffpra_pkg::rsp_t      seq_rsp;
    ffpra_pkg::entry_t    wdata, rdata;
    logic [IDX_W-1:0]     waddr, raddr;
    logic                 we, out_free, start;

    // The output register can take a new result when it is empty or its
    // current result leaves in this cycle.
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = !stat.idle;
    assign start     = req_valid && stat.idle;
    assign cfg_ready = 1'b1;

    ffpra_seq #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDX_W       (IDX_W),
        .UW          (UW)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req       (req),
        .base_page (base_reg),
        .end_page  (end_reg),
        .rsp_ready (out_free),
        .stat      (stat),
        .rsp       (seq_rsp),
        .we        (we),
        .waddr     (waddr),
        .wdata     (wdata),
        .raddr     (raddr),
        .rdata     (rdata)
    );

    ffpra_region_ram #(
        .DEPTH (TABLE_DEPTH),
        .AW    (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Configuration registers; writes to unknown indexes are dropped.
    always_comb
    begin
        base_next = base_reg;
        end_next  = end_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                ffpra_pkg::CFG_BASE_PAGE: base_next = cfg_data;
                ffpra_pkg::CFG_END_PAGE:  end_next  = cfg_data;
                default:                  base_next = base_reg;
            endcase
        end
    end

    // Output register.
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (stat.res_valid && out_free)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = seq_rsp;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= '0;
            end_reg       <= '1;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            base_reg      <= base_next;
            end_reg       <= end_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("second request taken while one is in progress");

    a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (stat.res_valid && !out_free) |=> stat.res_valid)
        else $error("result dropped while output register was full");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (stat.res_valid && out_free) |=> rsp_valid)
        else $error("result not presented after load");
`endif

endmodule

// ===== sv/ffpra_region_ram.sv =====
// ----------------------------------------------------------------------------
// Region table memory
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module ffpra_region_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                clk,
    input  logic                we,
    input  logic [AW-1:0]       waddr,
    input  ffpra_pkg::entry_t   wdata,
    input  logic [AW-1:0]       raddr,
    output ffpra_pkg::entry_t   rdata
);

    ffpra_pkg::entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/ffpra_seq.sv =====
// ----------------------------------------------------------------------------
// Request sequencer
// Scans the region table in order, updates the matching entry, closes up the
// table on a split and appends new regions.
// ----------------------------------------------------------------------------
module ffpra_seq #(
    parameter int TABLE_DEPTH = 64,
    parameter int IDX_W       = 6,
    parameter int UW          = 7
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  ffpra_pkg::req_t                     req,
    input  logic [ffpra_pkg::PAGE_W-1:0]        base_page,
    input  logic [ffpra_pkg::PAGE_W-1:0]        end_page,
    input  logic                                rsp_ready,
    output ffpra_pkg::seq_stat_t                stat,
    output ffpra_pkg::rsp_t                     rsp,
    output logic                                we,
    output logic [IDX_W-1:0]                    waddr,
    output ffpra_pkg::entry_t                   wdata,
    output logic [IDX_W-1:0]                    raddr,
    input  ffpra_pkg::entry_t                   rdata
);

    ffpra_pkg::state_t  state_reg, state_next;
    ffpra_pkg::req_t    req_reg, req_next;
    ffpra_pkg::rsp_t    res_reg, res_next;
    logic [UW-1:0]      idx_reg, idx_next;
    logic [UW-1:0]      used_reg, used_next;
    logic [IDX_W-1:0]   chk_idx_reg, chk_idx_next;
    logic               chk_vld_reg, chk_vld_next;
    logic [ffpra_pkg::PAGE_W-1:0] bump_reg, bump_next;
    logic [ffpra_pkg::PAGE_W-1:0] s_reg, s_next;
    logic [ffpra_pkg::CNT_W-1:0]  c_reg, c_next;

    logic                         is_alloc, cnt_eq, cnt_lt, hit, more, scan_end;
    logic                         table_full, exhausted, rd_en;
    logic [ffpra_pkg::SUM_W-1:0]  bump_page, bump_end, bump_sum;
    logic [UW-1:0]                used_m1;
    logic [IDX_W-1:0]             chk_m1;

    assign is_alloc   = req_reg.req_type == ffpra_pkg::REQ_ALLOC;
    assign cnt_eq     = rdata.page_count == req_reg.page_count;
    assign cnt_lt     = rdata.page_count < req_reg.page_count;
    assign hit        = chk_vld_reg && (is_alloc ? (rdata.free_mark && !cnt_lt)
                                                 : (rdata.start_page == req_reg.start_page));
    assign more       = idx_reg < used_reg;
    assign scan_end   = !chk_vld_reg && !more;
    assign table_full = used_reg == UW'(TABLE_DEPTH);
    assign bump_page  = ffpra_pkg::SUM_W'(base_page) + ffpra_pkg::SUM_W'(bump_reg);
    assign bump_end   = bump_page + ffpra_pkg::SUM_W'(req_reg.page_count);
    assign bump_sum   = ffpra_pkg::SUM_W'(bump_reg) + ffpra_pkg::SUM_W'(req_reg.page_count);
    assign exhausted  = !(bump_end < ffpra_pkg::SUM_W'(end_page));
    assign used_m1    = used_reg - UW'(1);
    assign chk_m1     = chk_idx_reg - IDX_W'(1);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ffpra_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = ffpra_pkg::S_SCAN;
                end
            end
            ffpra_pkg::S_SCAN:
            begin
                if (hit)
                begin
                    if (is_alloc && !cnt_eq && !table_full)
                    begin
                        state_next = ffpra_pkg::S_SHIFT;
                    end
                    else
                    begin
                        state_next = ffpra_pkg::S_RESP;
                    end
                end
                else if (scan_end)
                begin
                    state_next = ffpra_pkg::S_RESP;
                end
            end
            ffpra_pkg::S_SHIFT:
            begin
                if (scan_end)
                begin
                    state_next = ffpra_pkg::S_APP_REM;
                end
            end
            ffpra_pkg::S_APP_REM:  state_next = ffpra_pkg::S_APP_USED;
            ffpra_pkg::S_APP_USED: state_next = ffpra_pkg::S_RESP;
            ffpra_pkg::S_RESP:
            begin
                if (rsp_ready)
                begin
                    state_next = ffpra_pkg::S_IDLE;
                end
            end
            default: state_next = ffpra_pkg::S_IDLE;
        endcase
    end

    // Datapath and memory port control.
    always_comb
    begin
        req_next     = req_reg;
        res_next     = res_reg;
        idx_next     = idx_reg;
        used_next    = used_reg;
        chk_idx_next = chk_idx_reg;
        chk_vld_next = 1'b0;
        bump_next    = bump_reg;
        s_next       = s_reg;
        c_next       = c_reg;
        we           = 1'b0;
        waddr        = chk_idx_reg;
        wdata        = rdata;
        raddr        = idx_reg[IDX_W-1:0];
        rd_en        = 1'b0;
        case (state_reg)
            ffpra_pkg::S_IDLE:
            begin
                if (start)
                begin
                    req_next = req;
                    idx_next = '0;
                end
            end
            ffpra_pkg::S_SCAN:
            begin
                rd_en        = more && !hit;
                chk_vld_next = rd_en;
                chk_idx_next = idx_reg[IDX_W-1:0];
                if (rd_en)
                begin
                    idx_next = idx_reg + UW'(1);
                end
                res_next = '{ffpra_pkg::ST_OK, rdata.start_page, req_reg.page_count};
                if (hit)
                begin
                    if (is_alloc)
                    begin
                        if (cnt_eq)
                        begin
                            we    = 1'b1;
                            wdata = '{rdata.start_page, rdata.page_count, 1'b0};
                        end
                        else if (table_full)
                        begin
                            res_next = '{ffpra_pkg::ST_FULL, '0, '0};
                        end
                        else
                        begin
                            // Remove this entry: close up from the next one on.
                            s_next       = rdata.start_page;
                            c_next       = rdata.page_count;
                            idx_next     = UW'(chk_idx_reg) + UW'(1);
                            chk_vld_next = 1'b0;
                        end
                    end
                    else if (!cnt_eq)
                    begin
                        res_next = '{ffpra_pkg::ST_MISMATCH, '0, '0};
                    end
                    else
                    begin
                        we    = 1'b1;
                        wdata = '{rdata.start_page, rdata.page_count, 1'b1};
                    end
                end
                else if (scan_end)
                begin
                    if (!is_alloc)
                    begin
                        res_next = '{ffpra_pkg::ST_NOT_FOUND, '0, '0};
                    end
                    else if (table_full)
                    begin
                        res_next = '{ffpra_pkg::ST_FULL, '0, '0};
                    end
                    else if (exhausted)
                    begin
                        res_next = '{ffpra_pkg::ST_EXHAUSTED, '0, '0};
                    end
                    else
                    begin
                        we        = 1'b1;
                        waddr     = used_reg[IDX_W-1:0];
                        wdata     = '{bump_page[ffpra_pkg::PAGE_W-1:0],
                                      req_reg.page_count, 1'b0};
                        used_next = used_reg + UW'(1);
                        bump_next = bump_sum[ffpra_pkg::PAGE_W-1:0];
                        res_next  = '{ffpra_pkg::ST_OK, bump_page[ffpra_pkg::PAGE_W-1:0],
                                      req_reg.page_count};
                    end
                end
            end
            ffpra_pkg::S_SHIFT:
            begin
                rd_en        = more;
                chk_vld_next = rd_en;
                chk_idx_next = idx_reg[IDX_W-1:0];
                if (rd_en)
                begin
                    idx_next = idx_reg + UW'(1);
                end
                if (chk_vld_reg)
                begin
                    we    = 1'b1;
                    waddr = chk_m1;
                    wdata = rdata;
                end
            end
            ffpra_pkg::S_APP_REM:
            begin
                we    = 1'b1;
                waddr = used_m1[IDX_W-1:0];
                wdata = '{s_reg + ffpra_pkg::PAGE_W'(req_reg.page_count),
                          c_reg - req_reg.page_count, 1'b1};
            end
            ffpra_pkg::S_APP_USED:
            begin
                we        = 1'b1;
                waddr     = used_reg[IDX_W-1:0];
                wdata     = '{s_reg, req_reg.page_count, 1'b0};
                used_next = used_reg + UW'(1);
                res_next  = '{ffpra_pkg::ST_OK, s_reg, req_reg.page_count};
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ffpra_pkg::S_IDLE;
            used_reg    <= '0;
            bump_reg    <= '0;
            chk_vld_reg <= 1'b0;
            idx_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            bump_reg    <= bump_next;
            chk_vld_reg <= chk_vld_next;
            idx_reg     <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        res_reg     <= res_next;
        chk_idx_reg <= chk_idx_next;
        s_reg       <= s_next;
        c_reg       <= c_next;
    end

    assign stat.idle      = state_reg == ffpra_pkg::S_IDLE;
    assign stat.res_valid = state_reg == ffpra_pkg::S_RESP;
    assign rsp            = res_reg;

`ifndef SYNTHESIS
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= UW'(TABLE_DEPTH))
        else $error("region count exceeds table depth");

    a_used_grows: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg != $past(used_reg) |-> used_reg == $past(used_reg) + UW'(1))
        else $error("region count changed by other than one");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ffpra_pkg::S_RESP && res_reg.status != ffpra_pkg::ST_OK)
        |-> (res_reg.region_page == '0 && res_reg.region_count == '0))
        else $error("failed request carries a region");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ffpra_pkg::S_SCAN || state_reg == ffpra_pkg::S_SHIFT)
        |-> idx_reg <= used_reg)
        else $error("scan ran past the last region");
`endif

endmodule
